>>> design/fbfl_pkg.sv
`timescale 1ns / 1ps

package fbfl_pkg;

	// fixed field widths of the block's ports
	localparam int TAG_W      = 31;
	localparam int IDX_PORT_W = 8;
	localparam int FREE_W     = 9;
	// wide enough to hold any pool size or index in the allowed range
	localparam int EXT_W      = 17;

	// command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_DOUBLE = 2'd1,
		ST_OWNER  = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef struct packed {
		status_t                 status;
		logic [IDX_PORT_W-1:0]   granted;
		logic [FREE_W-1:0]       free_cnt;
	} result_t;

endpackage

>>> design/fbfl_ram.sv
`timescale 1ns / 1ps

module fbfl_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	assign rdata = rd_q;

endmodule

>>> design/fbfl_init.sv
`timescale 1ns / 1ps

module fbfl_init #(
	parameter int NUM_BLOCKS = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	output logic                          active,
	output logic [$clog2(NUM_BLOCKS)-1:0] addr,
	output logic [$clog2(NUM_BLOCKS):0]   wdata
);

	localparam int IDX_W = $clog2(NUM_BLOCKS);

	logic [IDX_W-1:0] cnt_q;
	logic             active_q;
	logic [IDX_W-1:0] cnt_inc;

	assign cnt_inc = cnt_q + IDX_W'(1);

	// sweep every entry: mark clear, link to the following block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			active_q <= 1'b1;
		end else if (active_q) begin
			cnt_q <= cnt_inc;
			if (cnt_q == IDX_W'(NUM_BLOCKS - 1)) begin
				active_q <= 1'b0;
			end
		end
	end

	assign active = active_q;
	assign addr   = cnt_q;
	assign wdata  = {1'b0, cnt_inc};

endmodule

>>> design/fixed_block_free_list_allocator_top.sv
`timescale 1ns / 1ps

// Fixed-pool block allocator. Hands out block indices from a LIFO free list and
// takes them back with double-free and owner checks. A command beat is taken
// when start is high and busy is low; it is registered in valid_s1, then done_q,
// and done pulses for one cycle with status, granted_index and free_blocks. The
// receiver cannot stall, so the result must be captured in that cycle. No new
// command is taken until the last one has read the combined link/in-use memory
// and written back its update. After reset busy stays high while the memory is
// swept to its initial chain, each block linked to the next index, with every
// in-use mark clear; tag writes are taken during that time. The user must write
// the allocator tag through tag_we/tag_wdata only while no command is in flight;
// the block itself does not enforce this. Frees of an index at or beyond
// NUM_BLOCKS report a wrong owner.
module fixed_block_free_list_allocator_top
	import fbfl_pkg::*;
#(
	parameter int NUM_BLOCKS = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// command beat
	input  logic                  start,
	output logic                  busy,
	input  logic                  cmd,
	input  logic [IDX_PORT_W-1:0] block_index,
	input  logic [TAG_W-1:0]      owner_tag,
	// allocator tag register
	input  logic                  tag_we,
	input  logic [TAG_W-1:0]      tag_wdata,
	// result beat
	output logic                  done,
	output logic [1:0]            status,
	output logic [IDX_PORT_W-1:0] granted_index,
	output logic [FREE_W-1:0]     free_blocks
);

	localparam int IDX_W = $clog2(NUM_BLOCKS);
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
	localparam int ENT_W = IDX_W + 1;   // {in_use, next_link}

	// sweep after reset
	logic             init_active;
	logic [IDX_W-1:0] init_addr;
	logic [ENT_W-1:0] init_wdata;

	// memory ports
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [ENT_W-1:0] ram_wdata;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [ENT_W-1:0] ram_rdata;

	// architectural state
	logic [TAG_W-1:0] tag_q;
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] free_q;

	// command in flight, waiting on the memory read
	logic             valid_s1;
	logic             cmd_s1;
	logic [IDX_W-1:0] blk_s1;
	logic             range_ok_s1;
	logic             tag_ok_s1;

	// result register
	logic             done_q;
	result_t          res_q;

	logic             accept;
	logic [EXT_W-1:0] blk_ext;
	logic [IDX_W-1:0] blk_addr;

	logic             upd_we;
	logic [IDX_W-1:0] upd_addr;
	logic [ENT_W-1:0] upd_data;
	logic [IDX_W-1:0] head_nx;
	logic [CNT_W-1:0] free_nx;
	status_t          st_nx;
	logic [IDX_W-1:0] granted_nx;
	result_t          res_nx;
	logic             rd_in_use;
	logic [IDX_W-1:0] rd_link;

	fbfl_init #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) u_init (
		.clk    (clk),
		.arst_n (arst_n),
		.active (init_active),
		.addr   (init_addr),
		.wdata  (init_wdata)
	);

	fbfl_ram #(
		.WIDTH(ENT_W),
		.DEPTH(NUM_BLOCKS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// one command at a time; the sweep holds commands off
	assign busy   = init_active | valid_s1;
	assign accept = start & ~busy;

	// block index widened so the range check and address work at any pool size
	assign blk_ext  = {{(EXT_W-IDX_PORT_W){1'b0}}, block_index};
	assign blk_addr = blk_ext[IDX_W-1:0];

	// read the head entry on alloc, the named block on free
	assign ram_re    = accept;
	assign ram_raddr = (cmd == CMD_FREE) ? blk_addr : head_q;

	// sweep owns the write port until done, then the update does
	assign ram_we    = init_active | upd_we;
	assign ram_waddr = init_active ? init_addr : upd_addr;
	assign ram_wdata = init_active ? init_wdata : upd_data;

	assign rd_in_use = ram_rdata[IDX_W];
	assign rd_link   = ram_rdata[IDX_W-1:0];

	// read-modify-write of the entry fetched last cycle
	always_comb begin
		upd_we     = 1'b0;
		upd_addr   = head_q;
		upd_data   = {1'b1, rd_link};
		head_nx    = head_q;
		free_nx    = free_q;
		st_nx      = ST_OK;
		granted_nx = '0;
		if (valid_s1) begin
			if (cmd_s1 == CMD_ALLOC) begin
				if (free_q == '0) begin
					st_nx = ST_EMPTY;
				end else begin
					// pop: mark the head in use, follow its link
					upd_we     = 1'b1;
					granted_nx = head_q;
					head_nx    = rd_link;
					free_nx    = free_q - CNT_W'(1);
				end
			end else begin
				upd_addr = blk_s1;
				upd_data = {1'b0, head_q};
				if (!range_ok_s1) begin
					st_nx = ST_OWNER;
				end else if (!rd_in_use) begin
					// double free wins over owner check
					st_nx = ST_DOUBLE;
				end else if (!tag_ok_s1) begin
					st_nx = ST_OWNER;
				end else begin
					// push: clear the mark, link to the old head
					upd_we  = 1'b1;
					head_nx = blk_s1;
					free_nx = free_q + CNT_W'(1);
				end
			end
		end
	end

	always_comb begin
		logic [EXT_W-1:0] g_ext;
		logic [EXT_W-1:0] f_ext;
		g_ext          = {{(EXT_W-IDX_W){1'b0}}, granted_nx};
		f_ext          = {{(EXT_W-CNT_W){1'b0}}, free_nx};
		res_nx.status   = st_nx;
		res_nx.granted  = g_ext[IDX_PORT_W-1:0];
		res_nx.free_cnt = f_ext[FREE_W-1:0];
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q    <= '0;
			head_q   <= '0;
			free_q   <= CNT_W'(NUM_BLOCKS);
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (tag_we) begin
				tag_q <= tag_wdata;
			end
			valid_s1 <= accept;
			done_q   <= valid_s1;
			if (valid_s1) begin
				head_q <= head_nx;
				free_q <= free_nx;
			end
		end
	end

	// command payload captured with the read
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= cmd;
			blk_s1      <= blk_addr;
			range_ok_s1 <= (blk_ext < EXT_W'(NUM_BLOCKS));
			tag_ok_s1   <= (owner_tag == tag_q);
		end
		if (valid_s1) begin
			res_q <= res_nx;
		end
	end

	assign done          = done_q;
	assign status        = res_q.status;
	assign granted_index = res_q.granted;
	assign free_blocks   = res_q.free_cnt;

endmodule

>>> design/fbfl_checker.sv
`timescale 1ns / 1ps

module fbfl_checker
	import fbfl_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic                  done,
	input logic [1:0]            status,
	input logic [IDX_PORT_W-1:0] granted_index,
	input logic [FREE_W-1:0]     free_blocks
);

	// every command beat is followed by its result beat
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result beat missing two cycles after command");

	// the block stays busy and shows no result beat in the cycle right after a command is taken
	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("block not busy or early result after command");

	// the block is ready again while its result is shown
	a_ready_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy while result beat shown");

	// out of blocks only with an empty list
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |-> (free_blocks == '0))
		else $error("out of blocks reported with free blocks left");

	// no index handed out on a failed command
	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (granted_index == '0))
		else $error("nonzero granted index on error");

endmodule

bind fixed_block_free_list_allocator_top fbfl_checker u_fbfl_checker (.*);
